// ===== rtl/lpl_pkg.sv =====
// shared types, constants and command bundle of the linked peak limiter
package lpl_pkg;

  // frame carries two samples; a value of 1 drops the right channel
  localparam int unsigned Channels = 2;
  localparam bit          UseRight = (Channels >= 2);

  localparam int unsigned SampleW  = 24;
  localparam int unsigned GainW    = 25;
  localparam int unsigned CfgW     = 24;
  localparam int unsigned ProdW    = CfgW + GainW;
  localparam int unsigned DivSteps = 24;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam int unsigned InDataW  = 2 * SampleW;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutRawW  = 2 * SampleW + 2 * GainW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - OutRawW;

  localparam logic [GainW-1:0] UnityGain = GainW'(1) << CfgW;
  localparam logic [CfgW-1:0]  CeilReset = 24'd14952811;
  localparam logic [CfgW-1:0]  CoefReset = 24'd16770227;

  typedef enum logic {
    CFG_CEILING = 1'b0,
    CFG_RELEASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEAK,
    ST_DIV,
    ST_REQ,
    ST_MUL,
    ST_REL,
    ST_SCL_L,
    ST_SCL_R,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic peak_init;
    logic div_step;
    logic div_first;
    logic req_calc;
    logic rel_mul;
    logic rel_apply;
    logic scl_left;
    logic scl_right;
    logic out_load;
  } lpl_cmd_t;

endpackage

// ===== rtl/lpl_dp.sv =====
// limiter datapath: peak, shift-subtract divider, envelope, shared multiplier, output register
module lpl_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpl_pkg::lpl_cmd_t           cmd_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lpl_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [lpl_pkg::InDataW-1:0] in_data_i,
  input  logic [lpl_pkg::InUserW-1:0] in_user_i,
  input  logic                        in_last_i,
  output logic [lpl_pkg::OutDataW-1:0] out_data_o,
  output logic                        out_last_o
);
  import lpl_pkg::*;

  logic [CfgW-1:0]     ceil_q, coef_q;
  logic [SampleW-1:0]  sl_q, sr_q;
  logic                eob_q;
  logic [SampleW-1:0]  peak_q;
  logic                over_q;
  logic [SampleW-1:0]  rem_q;
  logic [SampleW-1:0]  quo_q;
  logic [GainW-1:0]    req_q, d_q;
  logic                rel_q;
  logic [GainW-1:0]    env_q, min_q;
  logic [ProdW-1:0]    prod_q;
  logic [SampleW-1:0]  outl_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  logic [SampleW-1:0] mag_l, mag_r, peak;
  logic               over;
  logic [SampleW:0]   div_shift;
  logic [SampleW+1:0] div_trial;
  logic               div_fit;
  logic [SampleW-1:0] rem_next;
  logic [GainW-1:0]   req;
  logic [CfgW-1:0]    mul_a;
  logic [GainW-1:0]   mul_b;
  logic [ProdW-1:0]   mul_res;
  logic [SampleW-1:0] scaled;
  logic               scaled_neg;
  logic [SampleW-1:0] scaled_out;
  logic [GainW-1:0]   min_out;

  assign mag_l = sl_q[SampleW-1] ? (~sl_q + SampleW'(1)) : sl_q;
  assign mag_r = sr_q[SampleW-1] ? (~sr_q + SampleW'(1)) : sr_q;
  assign peak  = (mag_r > mag_l) ? mag_r : mag_l;
  assign over  = {peak, 1'b0} > {1'b0, ceil_q};

  // one quotient bit per step, dividend is ceiling shifted up by 23
  assign div_shift = {rem_q, (cmd_i.div_first ? ceil_q[0] : 1'b0)};
  assign div_trial = {1'b0, div_shift} - {2'b00, peak_q};
  assign div_fit   = ~div_trial[SampleW+1];
  assign rem_next  = div_fit ? div_trial[SampleW-1:0] : div_shift[SampleW-1:0];

  assign req = over_q ? {1'b0, quo_q} : UnityGain;

  always_comb begin
    if (cmd_i.rel_mul) begin
      mul_a = coef_q;
      mul_b = d_q;
    end else begin
      mul_a = cmd_i.scl_right ? mag_r : mag_l;
      mul_b = env_q;
    end
  end
  assign mul_res = ProdW'(mul_a) * ProdW'(mul_b);

  assign scaled     = prod_q[ProdW-2:CfgW];
  assign scaled_neg = cmd_i.out_load ? sr_q[SampleW-1] : sl_q[SampleW-1];
  assign scaled_out = scaled_neg ? (~scaled + SampleW'(1)) : scaled;
  assign min_out    = eob_q ? min_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= CeilReset;
      coef_q <= CoefReset;
      env_q  <= UnityGain;
      min_q  <= UnityGain;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CEILING: ceil_q <= cfg_data_i;
          CFG_RELEASE: coef_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (cmd_i.req_calc && (req < env_q)) begin
        env_q <= req;
      end
      if (cmd_i.rel_apply && rel_q) begin
        env_q <= req_q - prod_q[ProdW-1:CfgW];
      end
      if (cmd_i.scl_left && (env_q < min_q)) begin
        min_q <= env_q;
      end
      if (cmd_i.out_load && eob_q) begin
        min_q <= UnityGain;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sl_q  <= in_user_i[0] ? '0 : in_data_i[SampleW-1:0];
      sr_q  <= (in_user_i[1] || !UseRight) ? '0 : in_data_i[InDataW-1:SampleW];
      eob_q <= in_last_i;
    end
    if (cmd_i.peak_init) begin
      peak_q <= peak;
      over_q <= over;
      rem_q  <= {1'b0, ceil_q[CfgW-1:1]};
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[SampleW-2:0], div_fit};
    end
    if (cmd_i.req_calc) begin
      req_q <= req;
      rel_q <= ~(req < env_q);
      d_q   <= req - env_q;
    end
    if (cmd_i.rel_mul || cmd_i.scl_left || cmd_i.scl_right) begin
      prod_q <= mul_res;
    end
    if (cmd_i.scl_right) begin
      outl_q <= scaled_out;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {{OutPadW{1'b0}}, min_out, env_q, scaled_out, outl_q};
      out_last_q <= eob_q;
    end
  end

  assign out_data_o = out_data_q;
  assign out_last_o = out_last_q;

  a_env_le_unity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= UnityGain)
    else $error("envelope above unity");

  a_min_le_unity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= UnityGain)
    else $error("block minimum above unity");

  a_release_below_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rel_apply |=> env_q <= req_q)
    else $error("release overshot the required gain");

endmodule

// ===== rtl/lpl_ctrl.sv =====
// limiter controller: frame sequencing, divider step count, output valid
module lpl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output lpl_pkg::lpl_cmd_t  cmd_o
);
  import lpl_pkg::*;

  localparam logic [CntW-1:0] LastStep = CntW'(DivSteps - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  lpl_cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_PEAK;
        end
      end
      ST_PEAK: begin
        cmd.peak_init = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_q == '0);
        if (cnt_q == LastStep) begin
          state_d = ST_REQ;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_REQ: begin
        cmd.req_calc = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd.rel_mul = 1'b1;
        state_d     = ST_REL;
      end
      ST_REL: begin
        cmd.rel_apply = 1'b1;
        state_d       = ST_SCL_L;
      end
      ST_SCL_L: begin
        cmd.scl_left = 1'b1;
        state_d      = ST_SCL_R;
      end
      ST_SCL_R: begin
        cmd.scl_right = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_tready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign cmd_o      = cmd;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten before it was taken");

  a_div_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == LastStep) |=> state_q == ST_REQ)
    else $error("divider did not finish after its last step");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !m_tready_i) |=> state_q == ST_OUT)
    else $error("result left while the output slot was full");

endmodule

// ===== rtl/linked_peak_limiter.sv =====
// top level of the stereo-linked peak limiter
//
// usage:
//   s_axis carries one frame per transaction: tdata holds the two Q1.23 samples,
//   tuser the two non-finite flags, tlast marks the last frame of a block.
//   m_axis returns one result per frame: limited samples, the envelope gain and,
//   on the block's last frame (tlast), the lowest gain seen in that block.
//   cfg_we_i/cfg_idx_i/cfg_data_i write ceiling (index 0) and release pole
//   (index 1); write them only while no frame is in flight.
// frame processing:
//   a new frame is accepted only in the idle state, after the result of the
//   previous frame has been loaded into the output register. the work per frame
//   is set by the 24-step restoring divider (ceiling / peak, one quotient bit
//   a cycle) plus a shared 24x25 multiplier used three times.
// reset:
//   envelope and block minimum return to unity, registers to their defaults.
// stalls:
//   a finished result waits in the output register while the next frame is
//   accepted and processed; the datapath holds only when a second result is
//   ready before the first one has been taken.
module linked_peak_limiter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [lpl_pkg::CfgW-1:0]     cfg_data_i,
  // input frames
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lpl_pkg::InDataW-1:0]  s_axis_tdata,  // sample_left, sample_right
  input  logic [lpl_pkg::InUserW-1:0]  s_axis_tuser,  // bad_left, bad_right
  input  logic                         s_axis_tlast,  // end_of_block
  // result frames
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lpl_pkg::OutDataW-1:0] m_axis_tdata,  // out_left, out_right,
                                                      // gain_applied, block_min_gain, pad
  output logic                         m_axis_tlast   // block_done
);
  import lpl_pkg::*;

  lpl_cmd_t cmd;

  // sequencing and handshake control
  lpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  // arithmetic, gain state and output register
  lpl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ===== dv/linked_peak_limiter_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the stereo-linked peak limiter, directed table plus random frames
module linked_peak_limiter_test;
  import lpl_pkg::*;

  // watchdog, far above the slowest legal run of all phases
  localparam int unsigned CycleLimit  = 1_000_000;
  // settle time after the last result
  localparam int unsigned DrainCycles = 64;

  localparam logic [CfgW-1:0] CeilMin = 24'd4214255;
  localparam logic [CfgW-1:0] CeilMax = 24'd16585166;
  localparam logic [CfgW-1:0] CoefMax = 24'hFFFFFF;

  // one input frame, as the limiter sees it
  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic               bad_left;
    logic               bad_right;
    logic               eob;
  } frame_t;

  // one limited frame
  typedef struct packed {
    logic [SampleW-1:0] out_left;
    logic [SampleW-1:0] out_right;
    logic [GainW-1:0]   gain;
    logic [GainW-1:0]   min_gain;
    logic               done;
  } limit_t;

  // directed row: frame, and a typed-in result where it is obvious
  typedef struct packed {
    frame_t frame;
    logic   typed;
    limit_t want;
  } row_t;

  // one random phase: register setting, idling and frame count
  typedef struct {
    logic [CfgW-1:0] ceiling;
    logic [CfgW-1:0] coef;
    int              src_idle;
    int              dst_idle;
    int              frames;
  } phase_t;

  localparam limit_t NoWant = '0;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  cfg_idx_e            cfg_idx  = CFG_CEILING;
  logic [CfgW-1:0]     cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic [InUserW-1:0]  s_tuser  = '0;
  logic                s_tlast  = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  // mirror of the limiter registers and state
  logic [CfgW-1:0]  ceil_gain = CeilReset;
  logic [CfgW-1:0]  rel_coef  = CoefReset;
  logic [GainW-1:0] env_gain  = UnityGain;
  logic [GainW-1:0] blk_min   = UnityGain;

  limit_t      pending_limits[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;

  linked_peak_limiter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),   // sample_left, sample_right
    .s_axis_tuser  (s_tuser),   // bad_left, bad_right
    .s_axis_tlast  (s_tlast),   // end_of_block
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata), // out_left, out_right, gain_applied, block_min_gain, pad
    .m_axis_tlast  (m_axis_tlast)  // block_done
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("linked_peak_limiter test failed");
      $finish;
    end
  end

  // magnitude of a Q1.23 sample; the most negative value maps to 2^23
  function automatic logic [SampleW-1:0] magnitude(input logic [SampleW-1:0] s);
    return s[SampleW-1] ? -s : s;
  endfunction

  // sample times Q1.24 gain, truncated toward zero
  function automatic logic [SampleW-1:0] scale_by(input logic [SampleW-1:0] s,
                                                  input logic [GainW-1:0]   g);
    logic [63:0]        prod;
    logic [SampleW-1:0] m;
    prod = 64'(magnitude(s)) * 64'(g);
    m    = prod[SampleW+CfgW-1:CfgW];
    return s[SampleW-1] ? -m : m;
  endfunction

  // advances the mirrored envelope by one frame and returns the limited frame
  function automatic limit_t limit_frame(input frame_t f);
    logic [SampleW-1:0] sl;
    logic [SampleW-1:0] sr;
    logic [SampleW-1:0] peak;
    logic [63:0]        req;
    logic [63:0]        step;
    limit_t             r;
    // flagged samples count as silence
    sl   = f.bad_left ? '0 : f.left;
    sr   = (f.bad_right || !UseRight) ? '0 : f.right;
    peak = magnitude(sl);
    if (magnitude(sr) > peak) peak = magnitude(sr);
    // ceiling is Q0.24, peak Q1.23: compare 2*peak against it
    if (peak != 0 && (64'(peak) << 1) > 64'(ceil_gain)) begin
      req = (64'(ceil_gain) << 23) / 64'(peak);
    end else begin
      req = 64'(UnityGain);
    end
    // instant attack, one-pole release
    if (req < 64'(env_gain)) begin
      env_gain = GainW'(req);
    end else begin
      step     = (64'(rel_coef) * (req - 64'(env_gain))) >> CfgW;
      env_gain = GainW'(req - step);
    end
    if (env_gain < blk_min) blk_min = env_gain;
    r.out_left  = scale_by(sl, env_gain);
    r.out_right = UseRight ? scale_by(sr, env_gain) : '0;
    r.gain      = env_gain;
    r.done      = f.eob;
    r.min_gain  = f.eob ? blk_min : '0;
    if (f.eob) blk_min = UnityGain;
    return r;
  endfunction

  // mix of full-range noise, loud, quiet, silent and extreme samples
  function automatic logic [SampleW-1:0] rand_sample();
    logic [SampleW-1:0] m;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SampleW'($urandom);
      4, 5:       m = SampleW'($urandom_range(6000000, 8388607));
      6, 7:       m = SampleW'($urandom_range(0, 2000000));
      8:          return '0;
      default:    return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic frame_t rand_frame(input logic eob);
    frame_t f;
    f.left      = rand_sample();
    f.right     = rand_sample();
    f.bad_left  = ($urandom_range(0, 11) == 0);
    f.bad_right = ($urandom_range(0, 11) == 0);
    f.eob       = eob;
    return f;
  endfunction

  // offers one frame, optionally after a gap, and records its expected result on acceptance
  task automatic send_frame(input frame_t f, input logic typed, input limit_t want);
    limit_t predicted;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= InDataW'({$urandom, $urandom});  // junk on the bus while idle
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {f.right, f.left};
    s_tuser  <= {f.bad_right, f.bad_left};
    s_tlast  <= f.eob;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // transaction accepted at this edge
    predicted = limit_frame(f);
    pending_limits.push_back(typed ? want : predicted);
  endtask

  // result side: random back-pressure and the scoreboard check
  always @(posedge clk_i) begin : result_side
    limit_t got;
    limit_t exp_r;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      got.out_left  = m_axis_tdata[SampleW-1:0];
      got.out_right = m_axis_tdata[2*SampleW-1:SampleW];
      got.gain      = m_axis_tdata[2*SampleW+GainW-1:2*SampleW];
      got.min_gain  = m_axis_tdata[2*SampleW+2*GainW-1:2*SampleW+GainW];
      got.done      = m_axis_tlast;
      if (pending_limits.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result transaction: left %0d right %0d gain %0d",
                   $signed(got.out_left), $signed(got.out_right), got.gain);
        end
      end else begin
        exp_r = pending_limits.pop_front();
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch (exp/act): left %0d/%0d right %0d/%0d gain %0d/%0d",
                     $signed(exp_r.out_left), $signed(got.out_left),
                     $signed(exp_r.out_right), $signed(got.out_right),
                     exp_r.gain, got.gain);
            $display("  block min %0d/%0d done %0b/%0b",
                     exp_r.min_gain, got.min_gain, exp_r.done, got.done);
          end
        end
      end
    end
    // receiver idles on a random share of the cycles
    m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  initial begin : stimulus
    row_t   dir_rows[$];
    phase_t phases[$];
    int     blk_left;

    // left, right, bad_left, bad_right, eob | typed | expected
    // silence right after reset: unity gain, block of one
    dir_rows.push_back('{'{24'd0, 24'd0, 1'b0, 1'b0, 1'b1}, 1'b1,
                         '{24'd0, 24'd0, UnityGain, UnityGain, 1'b1}});
    // quiet frame passes untouched
    dir_rows.push_back('{'{24'd1000, -24'sd1000, 1'b0, 1'b0, 1'b0}, 1'b1,
                         '{24'd1000, -24'sd1000, UnityGain, 25'd0, 1'b0}});
    // both flagged: extremes become silence
    dir_rows.push_back('{'{24'h800000, 24'h7FFFFF, 1'b1, 1'b1, 1'b0}, 1'b1,
                         '{24'd0, 24'd0, UnityGain, 25'd0, 1'b0}});
    // full-scale peaks on each side, then release
    dir_rows.push_back('{'{24'h7FFFFF, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd0, 24'h800000, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd0, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    // one flagged side, the other carries the peak
    dir_rows.push_back('{'{24'h7FFFFF, 24'd100, 1'b1, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{-24'sd5, 24'h800000, 1'b0, 1'b1, 1'b1}, 1'b0, NoWant});
    dir_rows.push_back('{'{-24'sd1, 24'd1, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    // just at and just above the default ceiling
    dir_rows.push_back('{'{24'd7476405, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd7476406, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{-24'sd7476406, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd0, 24'd7476406, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'h800000, 24'h7FFFFF, 1'b0, 1'b0, 1'b1}, 1'b0, NoWant});
    // silent tail, block minimum reported at its end
    dir_rows.push_back('{'{24'd0, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd0, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd0, 24'd0, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'd0, 24'd0, 1'b0, 1'b0, 1'b1}, 1'b0, NoWant});
    // alternating bit patterns
    dir_rows.push_back('{'{24'h555555, 24'hAAAAAA, 1'b0, 1'b0, 1'b0}, 1'b0, NoWant});
    dir_rows.push_back('{'{24'hAAAAAA, 24'h555555, 1'b0, 1'b0, 1'b1}, 1'b0, NoWant});

    // ceiling, release pole, sender idle, receiver idle, frames
    phases.push_back('{CfgW'($urandom_range(CeilMin, CeilMax)), CfgW'($urandom),
                       30, 73, 250});
    phases.push_back('{CeilMin, '0, 73, 30, 200});
    phases.push_back('{CeilMax, CoefMax, 0, 0, 200});
    phases.push_back('{CeilMin, CoefMax, 30, 73, 200});
    phases.push_back('{CeilMax, '0, 73, 30, 200});
    phases.push_back('{CeilReset, CoefReset, 0, 0, 250});

    src_idle_pct = 30;
    dst_idle_pct = 73;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs on the reset register values
    foreach (dir_rows[i]) send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);
    s_tvalid <= 1'b0;

    foreach (phases[p]) begin
      // registers change only with nothing in flight
      while (pending_limits.size() != 0) @(posedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_CEILING;
      cfg_data <= phases[p].ceiling;
      @(posedge clk_i);
      cfg_idx  <= CFG_RELEASE;
      cfg_data <= phases[p].coef;
      @(posedge clk_i);
      cfg_we   <= 1'b0;
      ceil_gain    = phases[p].ceiling;
      rel_coef     = phases[p].coef;
      src_idle_pct = phases[p].src_idle;
      dst_idle_pct = phases[p].dst_idle;
      // frames grouped into blocks of random length, tlast on the last one
      blk_left = $urandom_range(1, 24);
      for (int n = 0; n < phases[p].frames; n++) begin
        blk_left--;
        send_frame(rand_frame(blk_left == 0), 1'b0, NoWant);
        if (blk_left == 0) blk_left = $urandom_range(1, 24);
      end
      s_tvalid <= 1'b0;
    end

    while (pending_limits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_limits.size() == 0) begin
      $display("linked_peak_limiter test passed");
    end else begin
      $display("linked_peak_limiter test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lpl_pkg.sv
rtl/lpl_dp.sv
rtl/lpl_ctrl.sv
rtl/linked_peak_limiter.sv
dv/linked_peak_limiter_test.sv
